/* rtl/core/spq_pkg.sv */
package spq_pkg;

   localparam int CAPACITY = 64;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } spq_status_type;

   typedef struct packed {
      logic                      ins;
      logic                      rem;
      logic signed [DATA_W-1:0]  value;
   } spq_op_type;

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell
   import spq_pkg::*;
(
   input  logic                     clock,
   input  spq_op_type               op,
   input  logic                     occupied,
   input  logic                     prev_gt,
   input  logic signed [DATA_W-1:0] prev_entry,
   input  logic signed [DATA_W-1:0] next_entry,
   output logic                     gt,
   output logic signed [DATA_W-1:0] entry
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   assign entry = entry_ff;
   assign gt    = occupied && (entry_ff > op.value);

   always_comb begin
      entry_in = entry_ff;
      if (op.ins) begin
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt || !occupied) begin
            entry_in = op.value;
         end
      end else if (op.rem) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/core/sorted_insert_priority_queue.sv */
// Sorted min-priority queue of CAPACITY signed 32-bit entries held in a row of
// cells, smallest first. Each request beat is an insert (mode 0) or a remove
// (mode 1) and gives exactly one response beat, registered in the cycle after the
// request is taken. Every cell compares and shifts in parallel, so one request
// is accepted in every cycle while the response side is not stalled. Equal
// values leave in arrival order. A remove on an empty queue answers status 1,
// an insert into a full queue answers status 2 and drops the value; result_value
// is zero except on a successful remove. No clearing pass is needed after reset.
module sorted_insert_priority_queue
   import spq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic [1:0]               rsp_status
);

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_value_in;
   spq_status_type           rsp_status_ff;
   spq_status_type           rsp_status_in;

   logic                     accept;
   logic                     is_empty;
   logic                     is_full;
   spq_op_type               op;

   logic                     gt_w    [CAPACITY];
   logic signed [DATA_W-1:0] entry_w [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));

   assign op.ins   = accept && (req_mode == MODE_INSERT) && !is_full;
   assign op.rem   = accept && (req_mode == MODE_REMOVE) && !is_empty;
   assign op.value = req_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     prev_gt;
      logic signed [DATA_W-1:0] prev_entry;
      logic signed [DATA_W-1:0] next_entry;

      if (i == 0) begin : g_first
         assign prev_gt    = 1'b0;
         assign prev_entry = req_value;
      end else begin : g_mid
         assign prev_gt    = gt_w[i-1];
         assign prev_entry = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = entry_w[i];
      end else begin : g_inner
         assign next_entry = entry_w[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .op         (op),
         .occupied   (count_ff > CNT_W'(i)),
         .prev_gt    (prev_gt),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .gt         (gt_w[i]),
         .entry      (entry_w[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = STATUS_OK;
         if (req_mode == MODE_INSERT) begin
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_value_in = entry_w[0];
               count_in     = count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
